// File: rtl/ip_search_tree_lookup_core_macros.svh
// Assertion macros for the search tree lookup core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef IP_SEARCH_TREE_LOOKUP_CORE_MACROS_SVH
`define IP_SEARCH_TREE_LOOKUP_CORE_MACROS_SVH

// Same-cycle implication, off during reset.
`define ISTL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("istl: same-cycle check failed");

// Next-cycle implication, off during reset.
`define ISTL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("istl: next-cycle check failed");

`endif

// File: rtl/istl_pkg.sv
// Shared types, codes and record decode for the search tree lookup core.
// No dependencies.
`timescale 1ns / 1ps

package istl_pkg;

    localparam int NODE_COUNT_W = 13;
    localparam int RSIZE_W      = 6;
    localparam int VER_W        = 3;
    localparam int CFG_W        = 32;
    localparam int REG_IDX_W    = 3;
    localparam int COUNT_W      = 8;
    localparam int ADDR_BITS    = 128;

    localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RECORD_SIZE  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TREE_VERSION = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SECTION_BASE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FILE_LENGTH  = 3'd4;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    localparam logic [1:0] STATUS_NOT_FOUND = 2'd0;
    localparam logic [1:0] STATUS_FOUND     = 2'd1;
    localparam logic [1:0] STATUS_ERROR     = 2'd2;

    localparam logic [RSIZE_W-1:0] RSIZE_24 = 6'd24;
    localparam logic [RSIZE_W-1:0] RSIZE_28 = 6'd28;
    localparam logic [VER_W-1:0]   VER_4    = 3'd4;
    localparam logic [VER_W-1:0]   VER_6    = 3'd6;

    localparam logic [COUNT_W-1:0] V4_WALK   = 8'd32;
    localparam logic [COUNT_W-1:0] FULL_WALK = 8'd128;
    localparam logic [31:0]        DELTA_MIN = 32'd16;
    localparam logic [7:0]         NIBBLE_MASK = 8'h0f;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_CHECK,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic mem_write;
        logic step;
        logic set_err;
        logic set_nf;
        logic latch_delta;
        logic check;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic v6_err;
        logic rec_eq;
        logic rec_gt;
        logic last_bit;
    } stat_t;

    function automatic logic [31:0] get_record(input logic [63:0] word,
                                               input logic [RSIZE_W-1:0] rsize,
                                               input logic dir);
        logic [7:0] mid;
        mid = word[39:32];
        if (rsize == RSIZE_24)
            get_record = dir ? {8'd0, word[39:16]} : {8'd0, word[63:40]};
        else if (rsize == RSIZE_28)
            get_record = dir ? {4'd0, mid[3:0] & NIBBLE_MASK[3:0], word[31:8]}
                             : {4'd0, mid[7:4], word[63:40]};
        else
            get_record = dir ? word[31:0] : word[63:32];
    endfunction

endpackage

// File: rtl/istl_ctrl.sv
// Controller state machine for the search tree lookup core.
// Depends on istl_pkg; drives istl_datapath through cmd_t.
`timescale 1ns / 1ps

module istl_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            mode,
    output logic            out_valid,
    input  logic            out_ready,
    input  istl_pkg::stat_t stat,
    output istl_pkg::cmd_t  cmd
);

    istl_pkg::state_t state_reg;
    istl_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;

    assign in_ready  = (state_reg == istl_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            istl_pkg::S_IDLE:
            begin
                if (accept && mode == istl_pkg::MODE_LOOKUP)
                    state_next = stat.v6_err ? istl_pkg::S_EMIT : istl_pkg::S_WALK;
            end
            istl_pkg::S_WALK:
            begin
                if (stat.rec_eq)
                    state_next = istl_pkg::S_EMIT;
                else if (stat.rec_gt)
                    state_next = istl_pkg::S_CHECK;
                else if (stat.last_bit)
                    state_next = istl_pkg::S_EMIT;
            end
            istl_pkg::S_CHECK:
                state_next = istl_pkg::S_EMIT;
            istl_pkg::S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = istl_pkg::S_IDLE;
            end
            default:
                state_next = istl_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            istl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (mode == istl_pkg::MODE_LOAD)
                        cmd.mem_write = 1'b1;
                    else
                    begin
                        cmd.start   = 1'b1;
                        cmd.set_err = stat.v6_err;
                    end
                end
            end
            istl_pkg::S_WALK:
            begin
                if (stat.rec_eq)
                    cmd.set_nf = 1'b1;
                else if (stat.rec_gt)
                    cmd.latch_delta = 1'b1;
                else
                begin
                    cmd.step   = 1'b1;
                    cmd.set_nf = stat.last_bit;
                end
            end
            istl_pkg::S_CHECK:
                cmd.check = 1'b1;
            istl_pkg::S_EMIT:
                cmd.load_out = !out_valid_reg || out_ready;
            default:
                cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= istl_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/istl_datapath.sv
// Datapath for the search tree lookup core: config registers, tree memory,
// address shifter, record decode and offset check. Depends on istl_pkg.
`timescale 1ns / 1ps

module istl_datapath
#(
    parameter int TREE_NODES = 4096
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  istl_pkg::cmd_t                    cmd,
    output istl_pkg::stat_t                   stat,
    input  logic [11:0]                       node_index,
    input  logic [63:0]                       node_word,
    input  logic [63:0]                       addr_hi,
    input  logic [63:0]                       addr_lo,
    input  logic                              addr_is_v4,
    input  logic                              wr_en,
    input  logic [istl_pkg::REG_IDX_W-1:0]    wr_index,
    input  logic [istl_pkg::CFG_W-1:0]        wr_data,
    output logic [1:0]                        status,
    output logic [31:0]                       record_offset
);

    localparam int AW = (TREE_NODES > 1) ? $clog2(TREE_NODES) : 1;

    logic [63:0] tree_mem [TREE_NODES];
    logic [63:0] mem_q_reg;
    logic [AW-1:0] rd_addr;

    logic [istl_pkg::NODE_COUNT_W-1:0] node_count_reg;
    logic [istl_pkg::RSIZE_W-1:0]      record_size_reg;
    logic [istl_pkg::VER_W-1:0]        tree_version_reg;
    logic [31:0]                       section_base_reg;
    logic [31:0]                       file_length_reg;

    logic [istl_pkg::ADDR_BITS-1:0] addr_reg;
    logic [istl_pkg::ADDR_BITS-1:0] addr_next;
    logic [istl_pkg::COUNT_W-1:0]   count_reg;
    logic [istl_pkg::COUNT_W-1:0]   count_next;
    logic                           node_ok_reg;
    logic [31:0]                    delta_reg;
    logic [1:0]                     res_status_reg;
    logic [31:0]                    res_offset_reg;
    logic [1:0]                     status_reg;
    logic [31:0]                    offset_reg;

    logic [31:0] nc_ext;
    logic [31:0] rec;
    logic [32:0] pos;
    logic        load_ok;

    assign nc_ext  = {{(32 - istl_pkg::NODE_COUNT_W){1'b0}}, node_count_reg};
    assign rec     = node_ok_reg
                   ? istl_pkg::get_record(mem_q_reg, record_size_reg,
                                          addr_reg[istl_pkg::ADDR_BITS-1])
                   : nc_ext;
    assign pos     = {1'b0, section_base_reg} + {1'b0, delta_reg}
                   - {1'b0, istl_pkg::DELTA_MIN};
    assign load_ok = ({20'd0, node_index} < 32'(TREE_NODES));
    assign rd_addr = cmd.start ? '0 : AW'(rec);

    assign stat.v6_err   = !addr_is_v4 && (tree_version_reg != istl_pkg::VER_6);
    assign stat.rec_eq   = (rec == nc_ext);
    assign stat.rec_gt   = (rec > nc_ext);
    assign stat.last_bit = (count_reg == istl_pkg::COUNT_W'(1));

    assign status        = status_reg;
    assign record_offset = offset_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_write && load_ok)
            tree_mem[AW'(node_index)] <= node_word;
    end

    always_ff @(posedge clk)
    begin
        mem_q_reg <= tree_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg   <= istl_pkg::NODE_COUNT_W'(1);
            record_size_reg  <= istl_pkg::RSIZE_24;
            tree_version_reg <= istl_pkg::VER_6;
            section_base_reg <= istl_pkg::DELTA_MIN;
            file_length_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                istl_pkg::REG_NODE_COUNT:
                    node_count_reg <= wr_data[istl_pkg::NODE_COUNT_W-1:0];
                istl_pkg::REG_RECORD_SIZE:
                    record_size_reg <= wr_data[istl_pkg::RSIZE_W-1:0];
                istl_pkg::REG_TREE_VERSION:
                    tree_version_reg <= wr_data[istl_pkg::VER_W-1:0];
                istl_pkg::REG_SECTION_BASE:
                    section_base_reg <= wr_data;
                istl_pkg::REG_FILE_LENGTH:
                    file_length_reg <= wr_data;
                default:
                    node_count_reg <= node_count_reg;
            endcase
        end
    end

    always_comb
    begin
        addr_next  = addr_reg;
        count_next = count_reg;
        if (cmd.start)
        begin
            if (!addr_is_v4)
            begin
                addr_next  = {addr_hi, addr_lo};
                count_next = istl_pkg::FULL_WALK;
            end
            else if (tree_version_reg == istl_pkg::VER_4)
            begin
                addr_next  = {addr_lo[31:0], 96'd0};
                count_next = istl_pkg::V4_WALK;
            end
            else
            begin
                addr_next  = {96'd0, addr_lo[31:0]};
                count_next = istl_pkg::FULL_WALK;
            end
        end
        else if (cmd.step)
        begin
            addr_next  = {addr_reg[istl_pkg::ADDR_BITS-2:0], 1'b0};
            count_next = count_reg - istl_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            node_ok_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.start)
                node_ok_reg <= (node_count_reg != '0);
            else if (cmd.step)
                node_ok_reg <= (rec < 32'(TREE_NODES));
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        if (cmd.latch_delta)
            delta_reg <= rec - nc_ext;
        if (cmd.set_err)
        begin
            res_status_reg <= istl_pkg::STATUS_ERROR;
            res_offset_reg <= '0;
        end
        else if (cmd.set_nf)
        begin
            res_status_reg <= istl_pkg::STATUS_NOT_FOUND;
            res_offset_reg <= '0;
        end
        else if (cmd.check)
        begin
            if (delta_reg >= istl_pkg::DELTA_MIN && pos < {1'b0, file_length_reg})
            begin
                res_status_reg <= istl_pkg::STATUS_FOUND;
                res_offset_reg <= pos[31:0];
            end
            else
            begin
                res_status_reg <= istl_pkg::STATUS_ERROR;
                res_offset_reg <= '0;
            end
        end
        if (cmd.load_out)
        begin
            status_reg <= res_status_reg;
            offset_reg <= res_offset_reg;
        end
    end

endmodule

// File: rtl/ip_search_tree_lookup_core.sv
// Top level of the search tree lookup core: binary trie walk over a node table.
// Depends on istl_pkg, istl_ctrl, istl_datapath and the assertion macro header.
//
//   channel   signals                                        handshake
//   input     mode node_index node_word addr_hi addr_lo      in_valid / in_ready
//             addr_is_v4
//   output    status record_offset                           out_valid / out_ready
//   config    wr_index wr_data                               wr_en, no wait
//
// A load word is written to tree memory when accepted. A lookup walks L levels
// (up to 32 on an IPv4 tree, else up to 128), one tree memory read per level,
// with an offset check on a data record hit; a family mismatch returns an error.
// Input is taken only when the walk is idle; a result waits in the output
// register and a finished lookup holds until that register frees up.
// Reset clears control and loads config defaults; tree memory has no clearing pass.
`timescale 1ns / 1ps
`include "ip_search_tree_lookup_core_macros.svh"

module ip_search_tree_lookup_core
#(
    parameter int TREE_NODES = 4096
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic [11:0]                    node_index,
    input  logic [63:0]                    node_word,
    input  logic [63:0]                    addr_hi,
    input  logic [63:0]                    addr_lo,
    input  logic                           addr_is_v4,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [31:0]                    record_offset,
    input  logic                           wr_en,
    input  logic [istl_pkg::REG_IDX_W-1:0] wr_index,
    input  logic [istl_pkg::CFG_W-1:0]     wr_data
);

    istl_pkg::cmd_t  cmd;
    istl_pkg::stat_t stat;

    istl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    istl_datapath
    #(
        .TREE_NODES (TREE_NODES)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .node_index    (node_index),
        .node_word     (node_word),
        .addr_hi       (addr_hi),
        .addr_lo       (addr_lo),
        .addr_is_v4    (addr_is_v4),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .status        (status),
        .record_offset (record_offset)
    );

    `ISTL_ASSERT_IMP(a_status_code, out_valid, status <= istl_pkg::STATUS_ERROR)
    `ISTL_ASSERT_IMP(a_offset_zero, out_valid && status != istl_pkg::STATUS_FOUND, record_offset == '0)
    `ISTL_ASSERT_NEXT(a_busy_after_lookup, in_valid && in_ready && mode == istl_pkg::MODE_LOOKUP, !in_ready)
    `ISTL_ASSERT_IMP(a_result_from_busy, $rose(out_valid), $past(!in_ready))

endmodule
